// File: sv/bdpsz_pkg.sv
// Shared types, constants and sequencing tables for the buffer sizer.
// Used by the register block, the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bdpsz_pkg;

    // Field and state widths.
    localparam int RATE_W    = 34;
    localparam int RTT_W     = 24;
    localparam int FRAC_W    = 16;
    localparam int PEAK_W    = RATE_W + FRAC_W;
    localparam int SMOOTH_W  = RTT_W + FRAC_W;
    localparam int SIZE_W    = 31;
    localparam int DECAY_W   = 16;
    localparam int WEIGHT_W  = 17;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 20;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int BDP_W     = PEAK_W + SMOOTH_W;

    // The divisor 2^(2*FRAC_W) * 4000000 is split into 2^(2*FRAC_W + 8) and 15625.
    localparam int DIV_D     = 15625;
    localparam int Y_SHIFT   = 2 * FRAC_W + 8;
    localparam int Y_W       = BDP_W - Y_SHIFT;
    localparam int QUO_W     = 32;
    localparam int DIGIT_W   = 4;
    localparam int REM_W     = 14;
    localparam int TRIAL_W   = REM_W + DIGIT_W;

    // Sequencer counts.
    localparam int STEP_W    = 4;
    localparam int DIV_CNT_W = 3;
    localparam logic [STEP_W-1:0]    LAST_STEP = STEP_W'(10);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(QUO_W / DIGIT_W - 1);

    // Configuration port.
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    localparam logic [WEIGHT_W-1:0] Q16_ONE      = WEIGHT_W'(65536);
    localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = SMOOTH_W'(64'd30000 << FRAC_W);
    localparam logic [SIZE_W-1:0]   SIZE_CAP     = 31'h7FFF_FFFF;
    localparam logic [SIZE_W-1:0]   ALIGNED_CAP  = 31'h7FFF_F000;
    localparam logic [SIZE_W:0]     ALIGN_ADD    = 32'd4095;

    localparam logic [SIZE_W-1:0]   MIN_SIZE_RST      = SIZE_W'(4194304);
    localparam logic [SIZE_W-1:0]   MAX_SIZE_RST      = SIZE_W'(33554432);
    localparam logic [DECAY_W-1:0]  PEAK_DECAY_RST    = DECAY_W'(65470);
    localparam logic [WEIGHT_W-1:0] RTT_WEIGHT_RST    = WEIGHT_W'(19661);
    localparam logic [SIZE_W-1:0]   DEFAULT_FLOOR_RST = SIZE_W'(1048576);
    localparam logic [SIZE_W-1:0]   IDLE_SIZE_RST     = SIZE_W'(8388608);

    typedef enum logic [2:0] {
        REG_MIN_SIZE      = 3'd0,
        REG_MAX_SIZE      = 3'd1,
        REG_PEAK_DECAY    = 3'd2,
        REG_RTT_WEIGHT    = 3'd3,
        REG_DEFAULT_FLOOR = 3'd4,
        REG_IDLE_SIZE     = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [SIZE_W-1:0]   min_size;
        logic [SIZE_W-1:0]   max_size;
        logic [DECAY_W-1:0]  peak_decay;
        logic [WEIGHT_W-1:0] rtt_weight;
        logic [SIZE_W-1:0]   default_floor;
        logic [SIZE_W-1:0]   idle_size;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RW,
        MUL_SHWO,
        MUL_SLWO,
        MUL_PD_HI,
        MUL_PD_LO,
        MUL_B00,
        MUL_B01,
        MUL_B10,
        MUL_B11
    } mul_sel_t;

    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_RTT_A,
        ACC_RTT_B,
        ACC_RTT_C,
        ACC_DEC_A,
        ACC_DEC_B,
        ACC_BDP_00,
        ACC_BDP_01,
        ACC_BDP_10,
        ACC_BDP_11
    } acc_op_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
    } step_cmd_t;

    typedef struct packed {
        logic      load_in;
        step_cmd_t step;
        logic      div_init;
        logic      div_step;
        logic      fin_load;
    } cmd_t;

    // A step starts at most one product and may fold in the one started the step before.
    function automatic step_cmd_t step_cmd(input logic [STEP_W-1:0] step);
        step_cmd_t c;
        case (step)
            4'd0:    c = '{mul_sel: MUL_RW,    acc_op: ACC_NONE};
            4'd1:    c = '{mul_sel: MUL_SHWO,  acc_op: ACC_RTT_A};
            4'd2:    c = '{mul_sel: MUL_SLWO,  acc_op: ACC_RTT_B};
            4'd3:    c = '{mul_sel: MUL_PD_HI, acc_op: ACC_RTT_C};
            4'd4:    c = '{mul_sel: MUL_PD_LO, acc_op: ACC_DEC_A};
            4'd5:    c = '{mul_sel: MUL_NONE,  acc_op: ACC_DEC_B};
            4'd6:    c = '{mul_sel: MUL_B00,   acc_op: ACC_NONE};
            4'd7:    c = '{mul_sel: MUL_B01,   acc_op: ACC_BDP_00};
            4'd8:    c = '{mul_sel: MUL_B10,   acc_op: ACC_BDP_01};
            4'd9:    c = '{mul_sel: MUL_B11,   acc_op: ACC_BDP_10};
            4'd10:   c = '{mul_sel: MUL_NONE,  acc_op: ACC_BDP_11};
            default: c = '{mul_sel: MUL_NONE,  acc_op: ACC_NONE};
        endcase
        return c;
    endfunction

    // Multiples of the divisor for radix-16 digit selection.
    function automatic logic [TRIAL_W-1:0] div_mult(input logic [DIGIT_W-1:0] k);
        return TRIAL_W'(int'(k) * DIV_D);
    endfunction

endpackage

`default_nettype wire

// File: sv/bdpsz_regs.sv
// Configuration register file with an APB-style access port.
// Depends on bdpsz_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module bdpsz_regs
    import bdpsz_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                REG_MIN_SIZE:      cfg_next.min_size      = pwdata[SIZE_W-1:0];
                REG_MAX_SIZE:      cfg_next.max_size      = pwdata[SIZE_W-1:0];
                REG_PEAK_DECAY:    cfg_next.peak_decay    = pwdata[DECAY_W-1:0];
                REG_RTT_WEIGHT:    cfg_next.rtt_weight    = pwdata[WEIGHT_W-1:0];
                REG_DEFAULT_FLOOR: cfg_next.default_floor = pwdata[SIZE_W-1:0];
                REG_IDLE_SIZE:     cfg_next.idle_size     = pwdata[SIZE_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MIN_SIZE:      prdata = DATA_W'(cfg_reg.min_size);
            REG_MAX_SIZE:      prdata = DATA_W'(cfg_reg.max_size);
            REG_PEAK_DECAY:    prdata = DATA_W'(cfg_reg.peak_decay);
            REG_RTT_WEIGHT:    prdata = DATA_W'(cfg_reg.rtt_weight);
            REG_DEFAULT_FLOOR: prdata = DATA_W'(cfg_reg.default_floor);
            REG_IDLE_SIZE:     prdata = DATA_W'(cfg_reg.idle_size);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_size      <= MIN_SIZE_RST;
            cfg_reg.max_size      <= MAX_SIZE_RST;
            cfg_reg.peak_decay    <= PEAK_DECAY_RST;
            cfg_reg.rtt_weight    <= RTT_WEIGHT_RST;
            cfg_reg.default_floor <= DEFAULT_FLOOR_RST;
            cfg_reg.idle_size     <= IDLE_SIZE_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/bdpsz_ctrl.sv
// Controller state machine: sequences the multiply steps, the divider and the
// output register. Depends on bdpsz_pkg for state_t, cmd_t and the step table.
`timescale 1ns / 1ps
`default_nettype none

module bdpsz_ctrl
    import bdpsz_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  wire logic m_tready,
    output cmd_t      cmd
);

    state_t                 state_reg;
    state_t                 state_next;
    logic [STEP_W-1:0]      step_reg;
    logic [STEP_W-1:0]      step_next;
    logic [DIV_CNT_W-1:0]   div_reg;
    logic [DIV_CNT_W-1:0]   div_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic                   out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_MUL;
            end
            ST_MUL: begin
                if (step_reg == LAST_STEP) state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV: begin
                if (div_reg == DIV_LAST) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd          = '0;
        cmd.step     = '{mul_sel: MUL_NONE, acc_op: ACC_NONE};
        step_next    = '0;
        div_next     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_MUL: begin
                cmd.step  = step_cmd(step_reg);
                step_next = step_reg + STEP_W'(1);
            end
            ST_DIV_INIT: cmd.div_init = 1'b1;
            ST_DIV: begin
                cmd.div_step = 1'b1;
                div_next     = div_reg + DIV_CNT_W'(1);
            end
            ST_FIN: cmd.fin_load = out_free;
            default: cmd = '0;
        endcase
    end

    assign m_valid_next = cmd.fin_load | (m_valid_reg & ~m_tready);
    assign m_tvalid     = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            div_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            div_reg     <= div_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A result may only be loaded when the output register is empty or draining.
    a_fin_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.fin_load |-> out_free)
        else $error("result loaded over a pending output item");

    // An accepted item always starts the multiply sequence at its first step.
    a_accept_starts_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_MUL && step_reg == '0))
        else $error("accepted item did not start the multiply sequence");

    // The multiply steps advance by one without skipping.
    a_step_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL && step_reg != LAST_STEP)
            |=> (state_reg == ST_MUL && step_reg == $past(step_reg) + STEP_W'(1)))
        else $error("multiply step sequence broken");

    // The output becomes valid only right after the finish state.
    a_valid_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("output valid raised outside the finish state");

endmodule

`default_nettype wire

// File: sv/bdpsz_dp.sv
// Datapath: shared 25x20 multiplier with accumulators, radix-16 divider by a
// constant, clamping and the output register. Depends on bdpsz_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdpsz_dp
    import bdpsz_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmd_t              cmd,
    input  wire cfg_t              cfg,
    input  wire logic [RATE_W-1:0] in_rx_rate,
    input  wire logic [RTT_W-1:0]  in_rtt_us,
    output logic      [SIZE_W-1:0] out_buffer_size,
    output logic      [SIZE_W-1:0] out_default_size,
    output logic                   out_changed
);

    logic [RATE_W-1:0]   rate_reg;
    logic [RTT_W-1:0]    rtt_reg;
    logic [PEAK_W-1:0]   peak_reg;
    logic [PEAK_W-1:0]   peak_next;
    logic [SMOOTH_W-1:0] smooth_reg;
    logic [SMOOTH_W-1:0] smooth_next;
    logic [SIZE_W-1:0]   last_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [PROD_W-1:0]   prod_next;
    logic [SMOOTH_W-1:0] racc_reg;
    logic [PEAK_W-1:0]   dec_reg;
    logic [BDP_W-1:0]    bdp_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [QUO_W-1:0]    num_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic                sat_reg;
    logic [SIZE_W-1:0]   buf_reg;
    logic [SIZE_W-1:0]   def_reg;
    logic                chg_reg;

    logic [WEIGHT_W-1:0] w_eff;
    logic [WEIGHT_W-1:0] w_old;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PEAK_W-1:0]   sample;
    logic [PEAK_W-1:0]   dec_sum;
    logic [Y_W-1:0]      y_val;
    logic [TRIAL_W-1:0]  trial;
    logic [DIGIT_W-1:0]  digit;
    logic [SIZE_W-1:0]   q_val;
    logic [SIZE_W-1:0]   lo_clamp;
    logic [SIZE_W-1:0]   hi_clamp;
    logic [SIZE_W:0]     rounded;
    logic [SIZE_W:0]     aligned;
    logic [SIZE_W-1:0]   buf_calc;
    logic [SIZE_W-1:0]   buf_val;
    logic [SIZE_W-1:0]   quarter;
    logic [SIZE_W-1:0]   def_val;

    // A weight above one acts as one.
    assign w_eff = cfg.rtt_weight[WEIGHT_W-1] ? Q16_ONE : cfg.rtt_weight;
    assign w_old = Q16_ONE - w_eff;

    always_comb begin
        case (cmd.step.mul_sel)
            MUL_RW: begin
                mul_a = MUL_A_W'(rtt_reg);
                mul_b = MUL_B_W'(w_eff);
            end
            MUL_SHWO: begin
                mul_a = MUL_A_W'(smooth_reg[SMOOTH_W-1:FRAC_W]);
                mul_b = MUL_B_W'(w_old);
            end
            MUL_SLWO: begin
                mul_a = MUL_A_W'(smooth_reg[FRAC_W-1:0]);
                mul_b = MUL_B_W'(w_old);
            end
            MUL_PD_HI: begin
                mul_a = peak_reg[PEAK_W-1:MUL_A_W];
                mul_b = MUL_B_W'(cfg.peak_decay);
            end
            MUL_PD_LO: begin
                mul_a = peak_reg[MUL_A_W-1:0];
                mul_b = MUL_B_W'(cfg.peak_decay);
            end
            MUL_B00: begin
                mul_a = peak_reg[MUL_A_W-1:0];
                mul_b = smooth_reg[MUL_B_W-1:0];
            end
            MUL_B01: begin
                mul_a = peak_reg[MUL_A_W-1:0];
                mul_b = smooth_reg[SMOOTH_W-1:MUL_B_W];
            end
            MUL_B10: begin
                mul_a = peak_reg[PEAK_W-1:MUL_A_W];
                mul_b = smooth_reg[MUL_B_W-1:0];
            end
            MUL_B11: begin
                mul_a = peak_reg[PEAK_W-1:MUL_A_W];
                mul_b = smooth_reg[SMOOTH_W-1:MUL_B_W];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    // The low half of the peak contributes only its product shifted down by FRAC_W.
    assign sample  = {rate_reg, {FRAC_W{1'b0}}};
    assign dec_sum = dec_reg + PEAK_W'(prod_reg[PROD_W-1:FRAC_W]);

    always_comb begin
        peak_next   = peak_reg;
        smooth_next = smooth_reg;
        case (cmd.step.acc_op)
            ACC_RTT_C: begin
                if (rtt_reg != '0) begin
                    smooth_next = racc_reg + SMOOTH_W'(prod_reg[PROD_W-1:FRAC_W]);
                end
            end
            ACC_DEC_B: peak_next = (sample > dec_sum) ? sample : dec_sum;
            default:   peak_next = peak_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg   <= '0;
            smooth_reg <= SMOOTH_RESET;
            last_reg   <= '0;
        end else begin
            peak_reg   <= peak_next;
            smooth_reg <= smooth_next;
            if (cmd.fin_load) last_reg <= buf_val;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (cmd.load_in) begin
            rate_reg <= in_rx_rate;
            rtt_reg  <= in_rtt_us;
        end
        case (cmd.step.acc_op)
            ACC_RTT_A:  racc_reg <= prod_reg[SMOOTH_W-1:0];
            ACC_RTT_B:  racc_reg <= racc_reg + prod_reg[SMOOTH_W-1:0];
            ACC_DEC_A:  dec_reg  <= PEAK_W'(prod_reg) << (MUL_A_W - FRAC_W);
            ACC_BDP_00: bdp_reg  <= BDP_W'(prod_reg);
            ACC_BDP_01: bdp_reg  <= bdp_reg + (BDP_W'(prod_reg) << MUL_B_W);
            ACC_BDP_10: bdp_reg  <= bdp_reg + (BDP_W'(prod_reg) << MUL_A_W);
            ACC_BDP_11: bdp_reg  <= bdp_reg + (BDP_W'(prod_reg) << (MUL_A_W + MUL_B_W));
            default:    bdp_reg  <= bdp_reg;
        endcase
    end

    // Long division of y_val by 15625, four quotient bits per cycle. When the
    // quotient would reach 2^31 the result saturates and the digits are ignored.
    assign y_val = bdp_reg[BDP_W-1:Y_SHIFT];
    assign trial = {rem_reg, num_reg[QUO_W-1:QUO_W-DIGIT_W]};

    always_comb begin
        digit = '0;
        for (int k = 1; k < (1 << DIGIT_W); k++) begin
            if (trial >= div_mult(DIGIT_W'(k))) digit = DIGIT_W'(k);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            sat_reg <= (y_val[Y_W-1:SIZE_W] >= (Y_W - SIZE_W)'(DIV_D));
            rem_reg <= y_val[QUO_W+REM_W-1:QUO_W];
            num_reg <= y_val[QUO_W-1:0];
            quo_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= REM_W'(trial - div_mult(digit));
            num_reg <= num_reg << DIGIT_W;
            quo_reg <= {quo_reg[QUO_W-DIGIT_W-1:0], digit};
        end
    end

    // Clamp, align up to 4096 and fall back to the idle size without a rate or rtt.
    always_comb begin
        q_val    = sat_reg ? SIZE_CAP : quo_reg[SIZE_W-1:0];
        lo_clamp = (q_val < cfg.min_size) ? cfg.min_size : q_val;
        hi_clamp = (lo_clamp > cfg.max_size) ? cfg.max_size : lo_clamp;
        rounded  = {1'b0, hi_clamp} + ALIGN_ADD;
        aligned  = {rounded[SIZE_W:12], 12'b0};
        buf_calc = (aligned > {1'b0, ALIGNED_CAP}) ? ALIGNED_CAP : aligned[SIZE_W-1:0];
        buf_val  = (peak_reg == '0 || smooth_reg == '0) ? cfg.idle_size : buf_calc;
        quarter  = buf_val >> 2;
        def_val  = (quarter < cfg.default_floor) ? cfg.default_floor : quarter;
    end

    always_ff @(posedge aclk) begin
        if (cmd.fin_load) begin
            buf_reg <= buf_val;
            def_reg <= def_val;
            chg_reg <= (buf_val != last_reg);
        end
    end

    assign out_buffer_size  = buf_reg;
    assign out_default_size = def_reg;
    assign out_changed      = chg_reg;

endmodule

`default_nettype wire

// File: sv/bdp_buffer_sizer_core.sv
// An accepted item passes through the 11 steps of the shared 25x20 multiplier, a
// divider setup state, the 8 radix-16 steps of the divider and a finish state, and
// the controller then returns to the idle state; no new item is taken before that.
// A stalled output holds the finish state until it drains.
// The next item is taken while the previous result waits in the output register.
// Reset (synchronous, active low) restores the register defaults, clears the peak
// rate and last size, and sets the smoothed rtt to 30000 us.
`timescale 1ns / 1ps
`default_nettype none

module bdp_buffer_sizer_core
    import bdpsz_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [63:0]       s_tdata,   // rx_rate[33:0], rtt_us[57:34], zero fill
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [63:0]       m_tdata,   // buffer_size[30:0], default_size[61:31], zero fill
    output logic                   m_tuser,   // changed
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t              cfg;
    cmd_t              cmd;
    logic [SIZE_W-1:0] buffer_size;
    logic [SIZE_W-1:0] default_size;

    bdpsz_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bdpsz_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bdpsz_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .cfg              (cfg),
        .in_rx_rate       (s_tdata[RATE_W-1:0]),
        .in_rtt_us        (s_tdata[RATE_W+RTT_W-1:RATE_W]),
        .out_buffer_size  (buffer_size),
        .out_default_size (default_size),
        .out_changed      (m_tuser)
    );

    assign m_tdata = {2'b00, default_size, buffer_size};

endmodule

`default_nettype wire
